[hdl/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// types, codes and default plan of the signal phase sequencer
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int PLAN_SLOTS = 8;
  localparam int IDX_W      = 3;
  localparam int LEN_W      = 4;
  localparam int TIME_W     = 20;
  localparam int STEP_W     = 16;
  localparam int KIND_W     = 2;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic [LEN_W-1:0] SLOTS_LEN   = LEN_W'(PLAN_SLOTS);
  localparam logic [LEN_W-1:0] DEFAULT_LEN = (PLAN_SLOTS < 6) ? LEN_W'(PLAN_SLOTS) : LEN_W'(6);

  // item kinds
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_EMERG = 2'd1;
  localparam logic [1:0] OP_ENTRY = 2'd2;

  // phase kinds
  localparam logic [KIND_W-1:0] KIND_NS_GREEN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EW_GREEN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_YELLOW   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ALL_RED  = 2'd3;

  // emergency status codes
  localparam logic [STAT_W-1:0] ST_NONE      = 3'd0;
  localparam logic [STAT_W-1:0] ST_ACCEPTED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_FLAGS = 3'd2;
  localparam logic [STAT_W-1:0] ST_EARLY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_LATE      = 3'd4;
  localparam logic [STAT_W-1:0] ST_WRONG_DIR = 3'd5;
  localparam logic [STAT_W-1:0] ST_NOT_GREEN = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EARLY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LATE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENSION = 2'd3;

  typedef struct packed {
    logic [STEP_W-1:0] tick_step_ms;
    logic [TIME_W-1:0] early_bound_ms;
    logic [TIME_W-1:0] late_bound_ms;
    logic [TIME_W-1:0] extension_ms;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] dur;
  } plan_wr_t;

  function automatic logic [KIND_W-1:0] dflt_kind(input int i);
    case (i)
      0:       dflt_kind = KIND_NS_GREEN;
      1:       dflt_kind = KIND_YELLOW;
      2:       dflt_kind = KIND_ALL_RED;
      3:       dflt_kind = KIND_EW_GREEN;
      4:       dflt_kind = KIND_YELLOW;
      5:       dflt_kind = KIND_ALL_RED;
      default: dflt_kind = KIND_NS_GREEN;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] dflt_time(input int i);
    case (i)
      0:       dflt_time = TIME_W'(30000);
      1:       dflt_time = TIME_W'(3000);
      2:       dflt_time = TIME_W'(2000);
      3:       dflt_time = TIME_W'(30000);
      4:       dflt_time = TIME_W'(3000);
      5:       dflt_time = TIME_W'(2000);
      default: dflt_time = '0;
    endcase
  endfunction

endpackage

[hdl/sps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sps_cfg_regs
// configuration registers written over the cfg channel
// ----------------------------------------------------------------------------
module sps_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sps_pkg::TIME_W-1:0]      cfg_data,
  output sps_pkg::cfg_t                   cfg
);
  import sps_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_step_ms   <= STEP_W'(100);
      cfg_r.early_bound_ms <= TIME_W'(10000);
      cfg_r.late_bound_ms  <= TIME_W'(5000);
      cfg_r.extension_ms   <= TIME_W'(20000);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TICK_STEP: cfg_r.tick_step_ms   <= cfg_data[STEP_W-1:0];
        CFG_EARLY:     cfg_r.early_bound_ms <= cfg_data;
        CFG_LATE:      cfg_r.late_bound_ms  <= cfg_data;
        CFG_EXTENSION: cfg_r.extension_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hdl/sps_plan_store.sv]
// ----------------------------------------------------------------------------
// sps_plan_store
// active and pending plan registers, pending plan copied into the active one on a swap
// ----------------------------------------------------------------------------
module sps_plan_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sps_pkg::plan_wr_t             wr,
  input  logic                          swap,
  input  logic [sps_pkg::IDX_W-1:0]     rd_idx,
  output logic [sps_pkg::KIND_W-1:0]    rd_kind,
  output logic [sps_pkg::TIME_W-1:0]    rd_time
);
  import sps_pkg::*;

  logic [KIND_W-1:0] act_kind_r  [PLAN_SLOTS];
  logic [TIME_W-1:0] act_time_r  [PLAN_SLOTS];
  logic [KIND_W-1:0] pend_kind_r [PLAN_SLOTS];
  logic [TIME_W-1:0] pend_time_r [PLAN_SLOTS];

  // read from the plan that is active after this item
  assign rd_kind = swap ? pend_kind_r[rd_idx] : act_kind_r[rd_idx];
  assign rd_time = swap ? pend_time_r[rd_idx] : act_time_r[rd_idx];

  // active plan holds the default plan after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLAN_SLOTS; i++) begin
        act_kind_r[i] <= dflt_kind(i);
        act_time_r[i] <= dflt_time(i);
      end
    end else if (swap) begin
      for (int i = 0; i < PLAN_SLOTS; i++) begin
        act_kind_r[i] <= pend_kind_r[i];
        act_time_r[i] <= pend_time_r[i];
      end
    end
  end

  // pending entries keep their contents across a swap
  always_ff @(posedge clk) begin
    if (wr.en) begin
      pend_kind_r[wr.idx] <= wr.kind;
      pend_time_r[wr.idx] <= wr.dur;
    end
  end

endmodule

[hdl/signal_phase_sequencer_top.sv]
// ----------------------------------------------------------------------------
// signal_phase_sequencer_top
// traffic signal phase sequencer with plan reload and emergency extension
// ----------------------------------------------------------------------------
// Every accepted item gives one result, valid in the cycle after it is taken;
// an item can be taken in every cycle while out_tready is high or the result
// register is empty, set by a single register stage of the phase counter,
// index and active plan. A new item is taken while a finished result waits
// only if out_tready is high. Configuration writes are always accepted.
module signal_phase_sequencer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // ns_request, ew_request, entry_index[2:0], entry_phase[1:0],
  // entry_duration[19:0], zero pad
  input  logic [sps_pkg::IN_DATA_W-1:0]      in_tdata,
  // opcode[1:0]
  input  logic [1:0]                         in_tuser,
  // entry_last
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // phase_now[1:0], phase_position[2:0], time_left_ms[19:0],
  // emergency_status[2:0], plan_switched, zero pad
  output logic [sps_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sps_pkg::TIME_W-1:0]         cfg_data
);
  import sps_pkg::*;

  cfg_t              cfg;
  plan_wr_t          plan_wr;
  logic              swap;
  logic [IDX_W-1:0]  rd_idx;
  logic [KIND_W-1:0] rd_kind;
  logic [TIME_W-1:0] rd_time;

  logic              in_fire;
  logic [1:0]        op;
  logic              ns_req;
  logic              ew_req;
  logic [IDX_W-1:0]  e_idx;
  logic [KIND_W-1:0] e_kind;
  logic [TIME_W-1:0] e_dur;

  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0]  act_len_r, act_len_nxt;
  logic [LEN_W-1:0]  pend_len_r, pend_len_nxt;
  logic              pend_rdy_r, pend_rdy_nxt;
  logic [STAT_W-1:0] status;

  logic [TIME_W-1:0] rem_dec;
  logic [LEN_W-1:0]  len_eff;
  logic [IDX_W-1:0]  idx_base;
  logic [LEN_W-1:0]  idx_inc;
  logic              advance;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  sps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sps_plan_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (plan_wr),
    .swap    (swap),
    .rd_idx  (rd_idx),
    .rd_kind (rd_kind),
    .rd_time (rd_time)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign op     = in_tuser;
  assign ns_req = in_tdata[0];
  assign ew_req = in_tdata[1];
  assign e_idx  = in_tdata[4:2];
  assign e_kind = in_tdata[6:5];
  assign e_dur  = in_tdata[26:7];

  // tick arithmetic
  assign rem_dec = (rem_r <= {{(TIME_W-STEP_W){1'b0}}, cfg.tick_step_ms}) ? '0 :
                   rem_r - {{(TIME_W-STEP_W){1'b0}}, cfg.tick_step_ms};
  assign advance = in_fire && (op == OP_TICK) && (rem_dec == '0);
  assign swap    = advance && (kind_r == KIND_ALL_RED) && pend_rdy_r &&
                   (pend_len_r >= LEN_W'(1)) && (pend_len_r <= SLOTS_LEN);
  assign len_eff = swap ? pend_len_r : act_len_r;
  assign idx_base = (swap && ({1'b0, idx_r} >= pend_len_r)) ? '0 : idx_r;
  assign idx_inc  = {1'b0, idx_base} + LEN_W'(1);
  assign rd_idx   = ((idx_inc >= len_eff) || (idx_inc >= SLOTS_LEN)) ? '0 :
                    idx_inc[IDX_W-1:0];

  always_comb begin
    plan_wr.en   = in_fire && (op == OP_ENTRY);
    plan_wr.idx  = e_idx;
    plan_wr.kind = e_kind;
    plan_wr.dur  = e_dur;
  end

  always_comb begin
    kind_nxt     = kind_r;
    idx_nxt      = idx_r;
    rem_nxt      = rem_r;
    act_len_nxt  = act_len_r;
    pend_len_nxt = pend_len_r;
    pend_rdy_nxt = pend_rdy_r;
    status       = ST_NONE;
    if (in_fire) begin
      case (op)
        OP_TICK: begin
          if (advance) begin
            idx_nxt  = rd_idx;
            kind_nxt = rd_kind;
            rem_nxt  = rd_time;
            if (swap) begin
              act_len_nxt  = pend_len_r;
              pend_rdy_nxt = 1'b0;
            end
          end else begin
            rem_nxt = rem_dec;
          end
        end
        OP_EMERG: begin
          if (kind_r != KIND_NS_GREEN && kind_r != KIND_EW_GREEN) begin
            status = ST_NOT_GREEN;
          end else if (ns_req == ew_req) begin
            status = ST_BAD_FLAGS;
          end else if (rem_r >= cfg.early_bound_ms) begin
            status = ST_EARLY;
          end else if (rem_r <= cfg.late_bound_ms) begin
            status = ST_LATE;
          end else if ((kind_r == KIND_NS_GREEN && !ns_req) ||
                       (kind_r == KIND_EW_GREEN && !ew_req)) begin
            status = ST_WRONG_DIR;
          end else begin
            status  = ST_ACCEPTED;
            rem_nxt = cfg.extension_ms;
          end
        end
        OP_ENTRY: begin
          if (in_tlast) begin
            pend_len_nxt = {1'b0, e_idx} + LEN_W'(1);
            pend_rdy_nxt = 1'b1;
          end else begin
            pend_rdy_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= dflt_kind(0);
      idx_r      <= '0;
      rem_r      <= dflt_time(0);
      act_len_r  <= DEFAULT_LEN;
      pend_len_r <= '0;
      pend_rdy_r <= 1'b0;
    end else begin
      kind_r     <= kind_nxt;
      idx_r      <= idx_nxt;
      rem_r      <= rem_nxt;
      act_len_r  <= act_len_nxt;
      pend_len_r <= pend_len_nxt;
      pend_rdy_r <= pend_rdy_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {{(OUT_DATA_W-29){1'b0}}, swap, status, rem_nxt, idx_nxt, kind_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[tb/sv/signal_phase_sequencer_checker.sv]
// ----------------------------------------------------------------------------
// signal_phase_sequencer_checker
// Watches the item, result and register channels of the phase sequencer,
// keeps its own copy of plan, timer and register state, works out the
// result of every accepted item and compares each result as it is taken.
// ----------------------------------------------------------------------------
module signal_phase_sequencer_checker
  import sps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TIME_W-1:0]     cfg_data,
  output int                    fail_count,
  output int                    awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  pos;
    logic [TIME_W-1:0] left;
    logic [STAT_W-1:0] status;
    logic              switched;
  } aspect_t;

  logic [STEP_W-1:0] tick_step;
  logic [TIME_W-1:0] early_bound;
  logic [TIME_W-1:0] late_bound;
  logic [TIME_W-1:0] extension;

  logic [KIND_W-1:0] act_kind [PLAN_SLOTS];
  logic [TIME_W-1:0] act_time [PLAN_SLOTS];
  logic [LEN_W-1:0]  act_len;
  logic [KIND_W-1:0] pend_kind [PLAN_SLOTS];
  logic [TIME_W-1:0] pend_time [PLAN_SLOTS];
  logic [LEN_W-1:0]  pend_len;
  logic              pend_ready;
  logic [IDX_W-1:0]  cur_idx;
  logic [TIME_W-1:0] remain;

  aspect_t aspect_q [$];

  task automatic reset_signal_state();
    tick_step   = STEP_W'(100);
    early_bound = TIME_W'(10000);
    late_bound  = TIME_W'(5000);
    extension   = TIME_W'(20000);
    for (int i = 0; i < PLAN_SLOTS; i++) begin
      act_kind[i]  = (i < 6) ? dflt_kind(i) : KIND_NS_GREEN;
      act_time[i]  = (i < 6) ? dflt_time(i) : '0;
      pend_kind[i] = KIND_NS_GREEN;
      pend_time[i] = '0;
    end
    act_len    = DEFAULT_LEN;
    pend_len   = '0;
    pend_ready = 1'b0;
    cur_idx    = '0;
    remain     = act_time[0];
  endtask

  task automatic advance_signal(input logic [1:0] op, input logic ns, input logic ew,
                                input logic [IDX_W-1:0] idx, input logic [KIND_W-1:0] ph,
                                input logic [TIME_W-1:0] dur, input logic last,
                                output aspect_t a);
    logic [KIND_W-1:0] k;
    logic [STAT_W-1:0] st;
    logic              sw;
    int                nxt;
    k  = act_kind[cur_idx];
    st = ST_NONE;
    sw = 1'b0;
    case (op)
      OP_TICK: begin
        if (remain <= tick_step) remain = '0;
        else remain = remain - tick_step;
        if (remain == '0) begin
          if (k == KIND_ALL_RED && pend_ready && pend_len >= 1 && pend_len <= SLOTS_LEN) begin
            act_kind   = pend_kind;
            act_time   = pend_time;
            act_len    = pend_len;
            if (cur_idx >= act_len) cur_idx = '0;
            pend_ready = 1'b0;
            sw         = 1'b1;
          end
          nxt = int'(cur_idx) + 1;
          if (nxt >= int'(act_len) || nxt >= PLAN_SLOTS) nxt = 0;
          cur_idx = IDX_W'(nxt);
          remain  = act_time[cur_idx];
        end
      end
      OP_EMERG: begin
        if (k != KIND_NS_GREEN && k != KIND_EW_GREEN) st = ST_NOT_GREEN;
        else if (ns == ew) st = ST_BAD_FLAGS;
        else if (remain >= early_bound) st = ST_EARLY;
        else if (remain <= late_bound) st = ST_LATE;
        else if ((k == KIND_NS_GREEN && !ns) || (k == KIND_EW_GREEN && !ew)) st = ST_WRONG_DIR;
        else begin
          st     = ST_ACCEPTED;
          remain = extension;
        end
      end
      OP_ENTRY: begin
        if (int'(idx) < PLAN_SLOTS) begin
          pend_kind[idx] = ph;
          pend_time[idx] = dur;
          if (last) begin
            pend_len   = LEN_W'(idx) + 1'b1;
            pend_ready = 1'b1;
          end else begin
            pend_ready = 1'b0;
          end
        end
      end
      default: ;
    endcase
    a.kind     = act_kind[cur_idx];
    a.pos      = cur_idx;
    a.left     = remain;
    a.status   = st;
    a.switched = sw;
  endtask

  task automatic report_mismatch(input string what, input aspect_t e, input aspect_t g);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: exp kind=%0d pos=%0d left=%0d status=%0d sw=%0d, got kind=%0d pos=%0d left=%0d status=%0d sw=%0d",
               $time, what, e.kind, e.pos, e.left, e.status, e.switched,
               g.kind, g.pos, g.left, g.status, g.switched);
  endtask

  always @(posedge clk) begin : watch
    aspect_t exp_a;
    aspect_t got;
    if (!rst_n) begin
      reset_signal_state();
      aspect_q.delete();
      fail_count = 0;
      awaiting   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TICK_STEP: tick_step   = cfg_data[STEP_W-1:0];
          CFG_EARLY:     early_bound = cfg_data;
          CFG_LATE:      late_bound  = cfg_data;
          CFG_EXTENSION: extension   = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        advance_signal(in_tuser, in_tdata[0], in_tdata[1], in_tdata[4:2], in_tdata[6:5],
                       in_tdata[26:7], in_tlast, exp_a);
        aspect_q.push_back(exp_a);
      end
      if (out_tvalid && out_tready) begin
        got.kind     = out_tdata[1:0];
        got.pos      = out_tdata[4:2];
        got.left     = out_tdata[24:5];
        got.status   = out_tdata[27:25];
        got.switched = out_tdata[28];
        if (aspect_q.size() == 0) begin
          exp_a = '{default: '0};
          report_mismatch("result with no item outstanding", exp_a, got);
        end else begin
          exp_a = aspect_q.pop_front();
          if (got.kind !== exp_a.kind || got.pos !== exp_a.pos || got.left !== exp_a.left ||
              got.status !== exp_a.status || got.switched !== exp_a.switched)
            report_mismatch("result mismatch", exp_a, got);
        end
      end
      awaiting = aspect_q.size();
    end
  end

endmodule

[tb/sv/signal_phase_sequencer_top_tb.sv]
// ----------------------------------------------------------------------------
// signal_phase_sequencer_top_tb
// Drives ticks, emergency requests, plan entry writes and unused opcodes into the phase
// sequencer under several register settings, with random gaps on both sides
// and one long receiver hold-off; the checker beside the block judges every
// result and this module gives the verdict.
// ----------------------------------------------------------------------------
module signal_phase_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sps_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 800000;
  localparam int         HOLD_CYCLES = 400;
  localparam int         HOLD_AFTER  = 600;
  localparam int         PHASE_ITEMS = 210;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = OP_TICK;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_TICK_STEP;
  logic [TIME_W-1:0]     cfg_data   = '0;

  int         fail_count;
  int         awaiting;
  int         cycle_count = 0;
  int         items_sent  = 0;
  int         cur_step    = 100;
  bit         hold_done   = 1'b0;
  logic [7:0] written     = '0;

  signal_phase_sequencer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  signal_phase_sequencer_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .awaiting   (awaiting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [TIME_W-1:0] pick_duration();
    int     r;
    longint d;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 8) return TIME_MAX;
    d = longint'(cur_step) * $urandom_range(0, 6) + $urandom_range(0, cur_step);
    return (d > longint'(TIME_MAX)) ? TIME_MAX : TIME_W'(d);
  endfunction

  task automatic send_item(input logic [1:0] op, input logic ns, input logic ew,
                           input logic [IDX_W-1:0] idx, input logic [KIND_W-1:0] ph,
                           input logic [TIME_W-1:0] dur, input logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= last;
    in_tdata  <= {5'd0, dur, ph, idx, ew, ns};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [STEP_W-1:0] step, input logic [TIME_W-1:0] early,
                              input logic [TIME_W-1:0] late, input logic [TIME_W-1:0] ext);
    write_reg(CFG_TICK_STEP, TIME_W'(step));
    write_reg(CFG_EARLY, early);
    write_reg(CFG_LATE, late);
    write_reg(CFG_EXTENSION, ext);
    cfg_valid <= 1'b0;
    cur_step = int'(step);
  endtask

  task automatic random_regs();
    int step;
    int late;
    step = ($urandom_range(0, 9) == 0) ? $urandom_range(3001, 65535) : $urandom_range(1, 3000);
    late = $urandom_range(0, 4 * step);
    program_regs(STEP_W'(step), TIME_W'(late + $urandom_range(0, 8 * step)), TIME_W'(late),
                 TIME_W'($urandom_range(0, 12 * step)));
  endtask

  // stop offering, wait for every outstanding result, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_item();
    int                r;
    int                n;
    logic              ns;
    logic [IDX_W-1:0]  idx;
    logic              lst;
    logic [31:0]       noise;
    r     = $urandom_range(0, 99);
    noise = $urandom;
    if (r < 12) begin
      n = $urandom_range(1, PLAN_SLOTS);
      for (int i = 0; i < n; i++) begin
        noise = $urandom;
        send_item(OP_ENTRY, noise[0], noise[1], IDX_W'(i), noise[3:2], pick_duration(),
                  i == n - 1);
        written[i] = 1'b1;
      end
    end else if (r < 40) begin
      ns = noise[26];
      if ($urandom_range(0, 4) == 0)
        send_item(OP_EMERG, ns, ns, noise[2:0], noise[4:3], noise[24:5], noise[25]);
      else
        send_item(OP_EMERG, ns, !ns, noise[2:0], noise[4:3], noise[24:5], noise[25]);
    end else if (r < 94) begin
      send_item(OP_TICK, noise[26], noise[27], noise[2:0], noise[4:3], noise[24:5], noise[25]);
    end else if (r < 97) begin
      send_item(OP_UNUSED, noise[26], noise[27], noise[2:0], noise[4:3], noise[24:5],
                noise[25]);
    end else begin
      // lone entry write; marked last only when every lower entry holds data
      idx = noise[2:0];
      lst = noise[25];
      for (int j = 0; j <= int'(idx); j++)
        if (!written[j] && j != int'(idx)) lst = 1'b0;
      send_item(OP_ENTRY, noise[26], noise[27], idx, noise[4:3], pick_duration(), lst);
      written[idx] = 1'b1;
    end
  endtask

  initial begin : receiver
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(50, 150)) @(posedge clk);
      else repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int target;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_regs(STEP_W'(22000), TIME_W'(10000), TIME_W'(5000), TIME_W'(20000));
    // emergency checks from the reset plan in north-south green
    send_item(OP_EMERG, 1'b1, 1'b1, '0, '0, '0, 1'b0);
    send_item(OP_EMERG, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    send_item(OP_EMERG, 1'b1, 1'b0, '0, '0, '0, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    send_item(OP_EMERG, 1'b0, 1'b1, '0, '0, '0, 1'b0);
    send_item(OP_EMERG, 1'b1, 1'b0, '0, '0, '0, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    send_item(OP_EMERG, 1'b1, 1'b0, '0, '0, '0, 1'b0);
    send_item(OP_UNUSED, 1'b1, 1'b1, '1, '1, TIME_MAX, 1'b1);
    // new plan, with the final entry rewritten to close it
    send_item(OP_ENTRY, 1'b0, 1'b0, IDX_W'(0), KIND_NS_GREEN, TIME_W'(9000), 1'b0);
    send_item(OP_ENTRY, 1'b0, 1'b0, IDX_W'(1), KIND_ALL_RED, '0, 1'b0);
    send_item(OP_ENTRY, 1'b0, 1'b0, IDX_W'(2), KIND_YELLOW, TIME_W'(1), 1'b0);
    send_item(OP_ENTRY, 1'b1, 1'b1, IDX_W'(7), KIND_ALL_RED, '0, 1'b0);
    send_item(OP_ENTRY, 1'b0, 1'b0, IDX_W'(2), KIND_EW_GREEN, TIME_MAX, 1'b1);
    written = 8'b1000_0111;
    send_item(OP_TICK, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    send_item(OP_EMERG, 1'b1, 1'b0, '0, '0, '0, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    send_item(OP_EMERG, 1'b0, 1'b1, '0, '0, '0, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    drain();

    for (int ph = 1; ph <= 8; ph++) begin
      case (ph)
        2:       program_regs(STEP_W'(1), TIME_MAX, '0, '0);
        5:       program_regs('1, '0, TIME_MAX, TIME_MAX);
        default: random_regs();
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_item();
      drain();
    end

    if (fail_count == 0 && awaiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[signal_phase_sequencer_top.f]
hdl/sps_pkg.sv
hdl/sps_cfg_regs.sv
hdl/sps_plan_store.sv
hdl/signal_phase_sequencer_top.sv
tb/sv/signal_phase_sequencer_checker.sv
tb/sv/signal_phase_sequencer_top_tb.sv
